@@ hw/rtl/tcw_pkg.sv @@
// tcw_pkg: screen geometry, character codes, command codes and the microcode
// store of the text console writer; shared by every tcw module
// no dependencies
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int PC_W       = 4;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;

    localparam logic [CHAR_W-1:0] COLOR_RESET = 8'd15;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // microprogram entry points and jump targets
    localparam logic [PC_W-1:0] PC_NEWLINE = 4'd0;
    localparam logic [PC_W-1:0] PC_ROW_INC = 4'd1;
    localparam logic [PC_W-1:0] PC_SCROLL  = 4'd2;
    localparam logic [PC_W-1:0] PC_COPY_RD = 4'd3;
    localparam logic [PC_W-1:0] PC_COPY_WR = 4'd4;
    localparam logic [PC_W-1:0] PC_LASTROW = 4'd5;
    localparam logic [PC_W-1:0] PC_BLANK   = 4'd6;
    localparam logic [PC_W-1:0] PC_AFTER_NL = 4'd7;
    localparam logic [PC_W-1:0] PC_STORE   = 4'd8;
    localparam logic [PC_W-1:0] PC_END     = 4'd9;
    localparam logic [PC_W-1:0] PC_CR      = 4'd10;
    localparam logic [PC_W-1:0] PC_CLEAR   = 4'd11;
    localparam logic [PC_W-1:0] PC_CLR_WR  = 4'd12;
    localparam logic [PC_W-1:0] PC_READ    = 4'd13;
    localparam logic [PC_W-1:0] PC_READ_END = 4'd14;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_STORE,
        UOP_ROW_INC,
        UOP_COL_ZERO,
        UOP_CLEAR_INIT,
        UOP_SCROLL_INIT,
        UOP_PTR_LASTROW,
        UOP_COPY_RD,
        UOP_COPY_WR,
        UOP_BLANK_WR,
        UOP_READ_CELL
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ROW_LAST,
        COND_PTR_NOT_END,
        COND_IS_LF
    } cond_t;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            fin;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic finish;
        uop_t uop;
    } ctrl_t;

    typedef struct packed {
        logic row_last;
        logic col_full;
        logic ptr_end;
        logic is_lf;
    } stat_t;

    // control store: jump taken when cond holds, else finish when fin, else step on
    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{uop: UOP_NONE, cond: COND_NEVER, target: PC_END, fin: 1'b1};
        case (pc)
            PC_NEWLINE:  w = '{UOP_NONE,        COND_ROW_LAST,    PC_SCROLL,   1'b0};
            PC_ROW_INC:  w = '{UOP_ROW_INC,     COND_ALWAYS,      PC_AFTER_NL, 1'b0};
            PC_SCROLL:   w = '{UOP_SCROLL_INIT, COND_NEVER,       PC_END,      1'b0};
            PC_COPY_RD:  w = '{UOP_COPY_RD,     COND_NEVER,       PC_END,      1'b0};
            PC_COPY_WR:  w = '{UOP_COPY_WR,     COND_PTR_NOT_END, PC_COPY_RD,  1'b0};
            PC_LASTROW:  w = '{UOP_PTR_LASTROW, COND_NEVER,       PC_END,      1'b0};
            PC_BLANK:    w = '{UOP_BLANK_WR,    COND_PTR_NOT_END, PC_BLANK,    1'b0};
            PC_AFTER_NL: w = '{UOP_NONE,        COND_IS_LF,       PC_END,      1'b0};
            PC_STORE:    w = '{UOP_STORE,       COND_NEVER,       PC_END,      1'b1};
            PC_END:      w = '{UOP_NONE,        COND_NEVER,       PC_END,      1'b1};
            PC_CR:       w = '{UOP_COL_ZERO,    COND_ALWAYS,      PC_STORE,    1'b0};
            PC_CLEAR:    w = '{UOP_CLEAR_INIT,  COND_NEVER,       PC_END,      1'b0};
            PC_CLR_WR:   w = '{UOP_BLANK_WR,    COND_PTR_NOT_END, PC_CLR_WR,   1'b1};
            PC_READ:     w = '{UOP_READ_CELL,   COND_NEVER,       PC_END,      1'b0};
            PC_READ_END: w = '{UOP_NONE,        COND_NEVER,       PC_END,      1'b1};
            default:     w = '{UOP_NONE,        COND_NEVER,       PC_END,      1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [11:0] full;
        full = 12'(row) * 12'(COLUMNS) + 12'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/tcw_screen_ram.sv @@
// tcw_screen_ram: screen cell memory, one write and one registered read per cycle
// depends on tcw_pkg
module tcw_screen_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tcw_pkg::ADDR_W-1:0]    waddr,
    input  logic [tcw_pkg::CELL_W-1:0]    wdata,
    input  logic [tcw_pkg::ADDR_W-1:0]    raddr,
    output logic [tcw_pkg::CELL_W-1:0]    rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tcw_sequencer.sv @@
// tcw_sequencer: step counter, control store lookup, branch and command dispatch
// depends on tcw_pkg
module tcw_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  tcw_pkg::stat_t                stat,
    output tcw_pkg::ctrl_t                ctrl,
    output logic                          busy
);

    logic                        active_reg;
    logic                        active_next;
    logic [tcw_pkg::PC_W-1:0]    pc_reg;
    logic [tcw_pkg::PC_W-1:0]    pc_next;
    logic [tcw_pkg::PC_W-1:0]    entry;
    tcw_pkg::ucode_t             word;
    logic                        cond_true;
    logic                        accept;

    assign accept = start && !active_reg;
    assign word   = tcw_pkg::ucode(pc_reg);

    always_comb
    begin
        case (op)
            tcw_pkg::OP_PUT:
            begin
                if (char_code == tcw_pkg::CH_LF)
                    entry = tcw_pkg::PC_NEWLINE;
                else if (char_code == tcw_pkg::CH_CR)
                    entry = tcw_pkg::PC_CR;
                else if (stat.col_full)
                    entry = tcw_pkg::PC_NEWLINE;
                else
                    entry = tcw_pkg::PC_STORE;
            end
            tcw_pkg::OP_CLEAR: entry = tcw_pkg::PC_CLEAR;
            tcw_pkg::OP_READ:  entry = tcw_pkg::PC_READ;
            default:           entry = tcw_pkg::PC_END;
        endcase
    end

    always_comb
    begin
        case (word.cond)
            tcw_pkg::COND_ALWAYS:      cond_true = 1'b1;
            tcw_pkg::COND_ROW_LAST:    cond_true = stat.row_last;
            tcw_pkg::COND_PTR_NOT_END: cond_true = !stat.ptr_end;
            tcw_pkg::COND_IS_LF:       cond_true = stat.is_lf;
            default:                   cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        pc_next     = pc_reg;
        if (active_reg)
        begin
            if (cond_true)
                pc_next = word.target;
            else if (word.fin)
                active_next = 1'b0;
            else
                pc_next = pc_reg + 1'b1;
        end
        else if (accept)
        begin
            active_next = 1'b1;
            pc_next     = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pc_reg     <= tcw_pkg::PC_END;
        end
        else
        begin
            active_reg <= active_next;
            pc_reg     <= pc_next;
        end
    end

    assign ctrl.accept = accept;
    assign ctrl.finish = active_reg && !cond_true && word.fin;
    assign ctrl.uop    = active_reg ? word.uop : tcw_pkg::UOP_NONE;
    assign busy        = active_reg;

endmodule

@@ hw/rtl/tcw_datapath.sv @@
// tcw_datapath: cursor, sweep pointer, color register, cell address and result words
// depends on tcw_pkg; drives the screen memory ports
module tcw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::ctrl_t                ctrl,
    input  logic [1:0]                    op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_W-1:0]     read_column,
    input  logic                          color_we,
    input  logic [tcw_pkg::CHAR_W-1:0]    color_data,
    output tcw_pkg::stat_t                stat,
    output logic                          mem_we,
    output logic [tcw_pkg::ADDR_W-1:0]    mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]    mem_wdata,
    output logic [tcw_pkg::ADDR_W-1:0]    mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata,
    output logic                          done,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row_out,
    output logic [tcw_pkg::COL_W-1:0]     cursor_column_out,
    output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]    cell_attr
);

    logic [tcw_pkg::ROW_W-1:0]   row_reg;
    logic [tcw_pkg::ROW_W-1:0]   row_next;
    logic [tcw_pkg::COL_W-1:0]   col_reg;
    logic [tcw_pkg::COL_W-1:0]   col_next;
    logic [tcw_pkg::ADDR_W-1:0]  ptr_reg;
    logic [tcw_pkg::ADDR_W-1:0]  ptr_next;
    logic [tcw_pkg::CHAR_W-1:0]  color_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;
    logic [tcw_pkg::ADDR_W-1:0]  rd_addr_reg;
    logic                        sel_reg;
    logic                        done_reg;
    logic [tcw_pkg::ROW_W-1:0]   row_out_reg;
    logic [tcw_pkg::COL_W-1:0]   col_out_reg;
    logic [tcw_pkg::CELL_W-1:0]  cell_reg;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        ptr_next  = ptr_reg;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = {color_reg, tcw_pkg::CH_SPACE};
        mem_raddr = ptr_reg;
        case (ctrl.uop)
            tcw_pkg::UOP_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcw_pkg::cell_addr(row_reg, col_reg);
                mem_wdata = {color_reg, char_reg};
                col_next  = col_reg + 1'b1;
            end
            tcw_pkg::UOP_ROW_INC:
            begin
                row_next = row_reg + 1'b1;
                col_next = '0;
            end
            tcw_pkg::UOP_COL_ZERO:
            begin
                col_next = '0;
            end
            tcw_pkg::UOP_CLEAR_INIT:
            begin
                row_next = '0;
                col_next = '0;
                ptr_next = '0;
            end
            tcw_pkg::UOP_SCROLL_INIT:
            begin
                col_next = '0;
                ptr_next = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
            end
            tcw_pkg::UOP_PTR_LASTROW:
            begin
                ptr_next = tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
            end
            tcw_pkg::UOP_COPY_RD:
            begin
                mem_raddr = ptr_reg;
            end
            tcw_pkg::UOP_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                mem_wdata = mem_rdata;
                ptr_next  = ptr_reg + 1'b1;
            end
            tcw_pkg::UOP_BLANK_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            tcw_pkg::UOP_READ_CELL:
            begin
                mem_raddr = rd_addr_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign stat.row_last = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign stat.col_full = (col_reg >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    assign stat.ptr_end  = (ptr_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1));
    assign stat.is_lf    = (char_reg == tcw_pkg::CH_LF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            color_reg <= tcw_pkg::COLOR_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            done_reg <= ctrl.finish;
            if (color_we)
            begin
                color_reg <= color_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctrl.accept)
        begin
            char_reg    <= char_code;
            rd_addr_reg <= tcw_pkg::cell_addr(read_row, read_column);
            sel_reg     <= (op == tcw_pkg::OP_READ)
                           && (read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                           && (read_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
        end
        if (ctrl.finish)
        begin
            row_out_reg <= row_next;
            col_out_reg <= col_next;
            cell_reg    <= sel_reg ? mem_rdata : '0;
        end
    end

    assign done              = done_reg;
    assign cursor_row_out    = row_out_reg;
    assign cursor_column_out = col_out_reg;
    assign cell_char         = cell_reg[tcw_pkg::CHAR_W-1:0];
    assign cell_attr         = cell_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];

endmodule

@@ hw/rtl/text_console_writer.sv @@
// text_console_writer: top level of the text console engine
// depends on tcw_pkg, tcw_screen_ram, tcw_sequencer, tcw_datapath
//
// A command is taken when start is high and busy is low; its one result is shown
// for a single cycle with done high and cannot be held off, so the receiver must
// take it then. A plain character costs one microcode step and a new command can
// start once busy is low again; carriage return and cell read take two steps, a
// line feed without scroll four. A line feed or wrap on the bottom row scrolls
// the screen through the cell memory, one read and one write step per cell moved
// plus one write per blank cell; clear writes every cell once. The text color
// register may be written whenever busy is low.
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_W-1:0]     read_column,
    output logic                          done,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row_out,
    output logic [tcw_pkg::COL_W-1:0]     cursor_column_out,
    output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]    cell_attr,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]    cfg_data
);

    tcw_pkg::ctrl_t              ctrl;
    tcw_pkg::stat_t              stat;
    logic                        mem_we;
    logic [tcw_pkg::ADDR_W-1:0]  mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
    logic [tcw_pkg::ADDR_W-1:0]  mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

    assign cfg_ready = !busy;

    tcw_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .char_code (char_code),
        .stat      (stat),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    tcw_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .op                (op),
        .char_code         (char_code),
        .read_row          (read_row),
        .read_column       (read_column),
        .color_we          (cfg_valid && cfg_ready),
        .color_data        (cfg_data),
        .stat              (stat),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata),
        .mem_raddr         (mem_raddr),
        .mem_rdata         (mem_rdata),
        .done              (done),
        .cursor_row_out    (cursor_row_out),
        .cursor_column_out (cursor_column_out),
        .cell_char         (cell_char),
        .cell_attr         (cell_attr)
    );

    tcw_screen_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // a result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");

    a_cursor_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_row_out < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor row beyond the screen");

    a_cursor_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_column_out <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
        else $error("cursor column beyond the line");

endmodule
